// File: rtl/broadcast_duplicate_filter_macros.svh
// Assertion macros of the duplicate filter RTL, used by the back end.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef BROADCAST_DUPLICATE_FILTER_MACROS_SVH
`define BROADCAST_DUPLICATE_FILTER_MACROS_SVH

`ifndef SYNTH
// Checked only while reset is released.
`define BDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BDF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BDF_ASSERT(lbl, prop, msg)
`define BDF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/bdf_pkg.sv
// Shared types and constants of the broadcast duplicate filter.
// Used by the front end, back end and top level; depends on nothing.
package bdf_pkg;

	localparam int HISTORY_DEPTH_DEF = 128;
	localparam logic [31:0] TIMEOUT_RESET = 32'd3000;
	localparam int SLOT_W = 7;

	typedef struct packed {
		logic [31:0] msg_checksum;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic              is_duplicate;
		logic [SLOT_W-1:0] slot_written;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_COMMIT
	} back_state_t;

endpackage

// File: rtl/bdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bdf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bdf_front.sv
// Front end of the duplicate filter: accepts requests into a two-entry queue.
// Depends on bdf_pkg.
module bdf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bdf_pkg::in_t  req,
	output logic          q_valid,
	output bdf_pkg::in_t  q_item,
	input  logic          q_pop
);

	bdf_pkg::in_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/bdf_back.sv
// Back end of the duplicate filter: scans the history memory for one request,
// then records it or flags it as a duplicate. Depends on bdf_pkg, bdf_ram and the macros header.
`include "broadcast_duplicate_filter_macros.svh"

module bdf_back #(
	parameter int HISTORY_DEPTH = bdf_pkg::HISTORY_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   timeout_ms,
	input  logic          q_valid,
	input  bdf_pkg::in_t  q_item,
	output logic          q_pop,
	output logic          done,
	output bdf_pkg::out_t rsp
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(HISTORY_DEPTH);

	bdf_pkg::back_state_t state_q, state_d;

	bdf_pkg::in_t  item_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] iss_q;
	logic          rd_v_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          v_s2;
	logic          eq_s2;
	logic [31:0]   age_s2;
	logic [AW-1:0] idx_s2;
	logic          hit_q;
	logic          have_q;
	logic [31:0]   best_age_q;
	logic [AW-1:0] best_idx_q;
	logic          done_q;
	bdf_pkg::out_t rsp_q;

	logic          rd_en;
	logic          commit;
	logic          wr_en;
	logic [AW-1:0] wr_slot;
	logic [63:0]   rd_data;
	logic [31:0]   slot_wide;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdf_pkg::ST_IDLE:   if (q_valid) state_d = bdf_pkg::ST_SCAN;
			bdf_pkg::ST_SCAN:   if (iss_q == fill_q) state_d = bdf_pkg::ST_FLUSH;
			bdf_pkg::ST_FLUSH:  if (!rd_v_s1 && !v_s2) state_d = bdf_pkg::ST_COMMIT;
			bdf_pkg::ST_COMMIT: state_d = bdf_pkg::ST_IDLE;
			default:            state_d = bdf_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		q_pop  = 1'b0;
		rd_en  = 1'b0;
		commit = 1'b0;
		case (state_q)
			bdf_pkg::ST_IDLE:   q_pop  = q_valid;
			bdf_pkg::ST_SCAN:   rd_en  = (iss_q != fill_q);
			bdf_pkg::ST_COMMIT: commit = 1'b1;
			default: begin
			end
		endcase
	end

	// Slots fill in index order and never empty, so the fill count is the
	// valid map; once full, the oldest slot is replaced.
	assign wr_en     = commit && !hit_q;
	assign wr_slot   = (fill_q != FULL) ? fill_q[AW-1:0] : best_idx_q;
	assign slot_wide = 32'(wr_slot);

	bdf_ram #(
		.WIDTH(64),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_slot),
		.wdata ({item_q.msg_checksum, item_q.now_ms}),
		.re    (rd_en),
		.raddr (iss_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		rd_idx_s1 <= iss_q[AW-1:0];
		idx_s2    <= rd_idx_s1;
		eq_s2     <= (rd_data[63:32] == item_q.msg_checksum);
		age_s2    <= item_q.now_ms - rd_data[31:0];
		rsp_q.is_duplicate <= hit_q;
		rsp_q.slot_written <= hit_q ? '0 : slot_wide[bdf_pkg::SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bdf_pkg::ST_IDLE;
			fill_q     <= '0;
			iss_q      <= '0;
			rd_v_s1    <= 1'b0;
			v_s2       <= 1'b0;
			hit_q      <= 1'b0;
			have_q     <= 1'b0;
			best_age_q <= '0;
			best_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			v_s2    <= rd_v_s1;
			done_q  <= commit;
			if (q_pop) begin
				iss_q  <= '0;
				hit_q  <= 1'b0;
				have_q <= 1'b0;
			end else if (rd_en) begin
				iss_q <= iss_q + CW'(1);
			end
			if (v_s2) begin
				if (eq_s2 && (age_s2 < timeout_ms)) begin
					hit_q <= 1'b1;
				end
				if (!have_q || (age_s2 > best_age_q)) begin
					have_q     <= 1'b1;
					best_age_q <= age_s2;
					best_idx_q <= idx_s2;
				end
			end
			if (wr_en && (fill_q != FULL)) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`BDF_ASSERT(a_fill_bounded, fill_q <= FULL, "history fill count beyond depth")
	`BDF_ASSERT(a_scan_in_range, rd_en |-> (iss_q < fill_q), "scan reads an empty slot")
	`BDF_ASSERT(a_dup_slot_zero, (done && rsp.is_duplicate) |-> (rsp.slot_written == '0), "duplicate reports a slot")
	`BDF_ASSERT(a_fill_on_record, (fill_q != $past(fill_q)) |-> $past(wr_en), "fill moved without a record")
	`BDF_ASSERT(a_pop_when_drained, q_pop |-> (!rd_v_s1 && !v_s2), "new request while scan in flight")

endmodule

// File: rtl/broadcast_duplicate_filter.sv
// Flow: a request waits in the two-entry queue, is popped, the scan reads the F filled history
// slots (F being at most HISTORY_DEPTH), the read pipeline drains, the result is committed and
// then strobed. One request is handled at a time, set by the history RAM's single read port,
// which the scan walks one slot per cycle; the next is popped only after the last is committed.
// Reset (arst_n low) empties the history and the queue and sets the timeout to 3000 ms;
// no clearing pass is needed. Results cannot be stalled by the receiver.
module broadcast_duplicate_filter #(
	parameter int HISTORY_DEPTH = bdf_pkg::HISTORY_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// Request channel: a beat is taken when start is high and busy is low.
	input  logic          start,
	output logic          busy,
	input  bdf_pkg::in_t  req,
	// Result channel: one beat per request, valid for the single cycle done is high.
	output logic          done,
	output bdf_pkg::out_t rsp,
	// Timeout register write channel.
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data
);

	logic         q_valid;
	bdf_pkg::in_t q_item;
	logic         q_pop;
	logic [31:0]  timeout_q;

	// The timeout register is always ready; the user must rewrite it only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= bdf_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// The front end buffers requests so the host sees busy only when two are waiting.
	bdf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// The back end scans the history, decides duplicate or new, and records new messages
	// in the lowest empty slot or, when full, in the oldest one.
	bdf_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.timeout_ms (timeout_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.done       (done),
		.rsp        (rsp)
	);

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of broadcast_duplicate_filter: a directed table, then random traffic.
// A local history predictor checks untyped results. Depends on bdf_pkg and the RTL top level.
module tb_top;

	localparam int DEPTH = bdf_pkg::HISTORY_DEPTH_DEF;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int WD_LIMIT = 4000;
	// Cycles to watch for stray results once the last one has arrived.
	localparam int TAIL_CYCLES = 3 * (DEPTH + 5);
	localparam int POOL_SIZE = 160;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 300;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// One line of the directed plan. A config row carries only cfg; an item row
	// carries a request and, where it is obvious, the result typed in by hand.
	typedef struct {
		row_kind_t     kind;
		bdf_pkg::in_t  msg;
		logic [31:0]   cfg;
		bit            typed;
		bdf_pkg::out_t want;
	} step_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	bdf_pkg::in_t  req;
	logic          done;
	bdf_pkg::out_t rsp;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [31:0]   cfg_data;

	// Shadow of the block's history and timeout register.
	logic [31:0]   seen_sum [DEPTH];
	logic [31:0]   seen_time [DEPTH];
	bit            seen_valid [DEPTH];
	logic [31:0]   timeout_q;

	// Results predicted for accepted requests, oldest first.
	bdf_pkg::out_t verdicts [$];
	bdf_pkg::out_t head;
	int            mismatches;
	int            idle_cycles;
	int            sender_idle_pct;

	// Extremes first: after reset, the exact timeout boundary, time wrap, zero and
	// all-ones timeout, then a few mixed rows left to the predictor.
	step_row_t plan [0:15] = '{
		'{ROW_ITEM, {32'h0000_0000, 32'h0000_0000}, 32'd0, 1'b1, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'h0000_0000, 32'd2999}, 32'd0, 1'b1, {1'b1, 7'd0}},
		'{ROW_ITEM, {32'h0000_0000, 32'd3000}, 32'd0, 1'b1, {1'b0, 7'd1}},
		'{ROW_ITEM, {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 32'd0, 1'b1, {1'b0, 7'd2}},
		'{ROW_ITEM, {32'hFFFF_FFFF, 32'h0000_0000}, 32'd0, 1'b1, {1'b1, 7'd0}},
		'{ROW_CFG, {32'h0, 32'h0}, 32'h0000_0000, 1'b0, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'h0000_0000, 32'd3000}, 32'd0, 1'b1, {1'b0, 7'd3}},
		'{ROW_CFG, {32'h0, 32'h0}, 32'hFFFF_FFFF, 1'b0, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'h0000_0000, 32'd3001}, 32'd0, 1'b1, {1'b1, 7'd0}},
		'{ROW_ITEM, {32'hFFFF_FFFF, 32'hFFFF_FFFE}, 32'd0, 1'b1, {1'b0, 7'd4}},
		'{ROW_CFG, {32'h0, 32'h0}, bdf_pkg::TIMEOUT_RESET, 1'b0, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'hA5A5_A5A5, 32'h00AB_CDEF}, 32'd0, 1'b0, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'h5A5A_5A5A, 32'hFF54_3210}, 32'd0, 1'b0, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'hA5A5_A5A5, 32'h00AB_CE53}, 32'd0, 1'b0, {1'b0, 7'd0}},
		'{ROW_CFG, {32'h0, 32'h0}, 32'h0000_0001, 1'b0, {1'b0, 7'd0}},
		'{ROW_ITEM, {32'h5A5A_5A5A, 32'hFF54_3210}, 32'd0, 1'b0, {1'b0, 7'd0}}
	};

	broadcast_duplicate_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Works out the verdict for one message and updates the shadow history the
	// way the block does: a live entry with the same checksum that is younger
	// than the timeout makes a duplicate; otherwise the message takes the lowest
	// empty slot, or the oldest one (lowest index on a tie).
	function automatic bdf_pkg::out_t filter_verdict(bdf_pkg::in_t msg);
		bdf_pkg::out_t r;
		logic [31:0]   age;
		logic [31:0]   oldest;
		bit            dup;
		bit            have;
		int            pick;
		r = '0;
		dup = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			age = msg.now_ms - seen_time[i];
			if (seen_valid[i] && seen_sum[i] == msg.msg_checksum && age < timeout_q)
				dup = 1'b1;
		end
		if (dup) begin
			r.is_duplicate = 1'b1;
			r.slot_written = '0;
			return r;
		end
		pick = 0;
		have = 1'b0;
		oldest = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (!seen_valid[i]) begin
				pick = i;
				break;
			end
			age = msg.now_ms - seen_time[i];
			if (!have || age > oldest) begin
				pick = i;
				oldest = age;
				have = 1'b1;
			end
		end
		seen_sum[pick] = msg.msg_checksum;
		seen_time[pick] = msg.now_ms;
		seen_valid[pick] = 1'b1;
		r.is_duplicate = 1'b0;
		r.slot_written = pick[bdf_pkg::SLOT_W-1:0];
		return r;
	endfunction

	// Offers one request beat, idling first at the current rate. Start stays high
	// after the accept so that a following beat can go out back to back.
	task automatic send_msg(input bdf_pkg::in_t msg, input bit typed, input bdf_pkg::out_t want);
		bdf_pkg::out_t pred;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			req = {$urandom, $urandom};
			@(negedge clk);
		end
		start = 1'b1;
		req = msg;
		do @(posedge clk); while (busy);
		pred = filter_verdict(msg);
		verdicts.push_back(typed ? want : pred);
	endtask

	// Writes the timeout only once every pending result has come back.
	task automatic write_timeout(input logic [31:0] value);
		@(negedge clk);
		start = 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		timeout_q = value;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = $urandom;
	endtask

	// Result checker: every done beat must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual dup=%0b slot=%0d",
					$time, rsp.is_duplicate, rsp.slot_written);
				mismatches++;
			end else begin
				head = verdicts.pop_front();
				if (rsp.is_duplicate !== head.is_duplicate) begin
					$display("%0t: is_duplicate mismatch: expected %0b, actual %0b",
						$time, head.is_duplicate, rsp.is_duplicate);
					mismatches++;
				end
				if (rsp.slot_written !== head.slot_written) begin
					$display("%0t: slot_written mismatch: expected %0d, actual %0d",
						$time, head.slot_written, rsp.slot_written);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: any accepted request, result or config beat counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WD_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [31:0]  pool [POOL_SIZE];
		logic [31:0]  phase_timeout [PHASES];
		int           phase_idle [PHASES];
		logic [31:0]  clock_ms;
		bdf_pkg::in_t msg;
		int           roll;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		sender_idle_pct = 0;
		timeout_q = bdf_pkg::TIMEOUT_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			seen_sum[i] = '0;
			seen_time[i] = '0;
			seen_valid[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, at full rate so the rows land back to back.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_timeout(plan[i].cfg);
			else
				send_msg(plan[i].msg, plan[i].typed, plan[i].want);
		end

		// Random part. A pool of recurring checksums, a bit larger than the
		// history, gives both duplicates and evictions; the clock mostly creeps
		// forward, often standing still so that ages tie.
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = $urandom;
		phase_timeout = '{bdf_pkg::TIMEOUT_RESET, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'd100, $urandom};
		phase_idle = '{0, 80, 8, 0, 80, 8};
		clock_ms = $urandom;
		for (int p = 0; p < PHASES; p++) begin
			write_timeout(phase_timeout[p]);
			sender_idle_pct = phase_idle[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				if (roll < 2)
					clock_ms = 32'hFFFF_FF00 + $urandom_range(255);
				else if (roll < 10)
					clock_ms = clock_ms + $urandom;
				else if (roll < 55)
					clock_ms = clock_ms + $urandom_range(50);
				if ($urandom_range(99) < 20)
					msg = {$urandom, $urandom};
				else
					msg = {pool[$urandom_range(POOL_SIZE - 1)], clock_ms};
				send_msg(msg, 1'b0, '0);
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/bdf_pkg.sv
rtl/bdf_ram.sv
rtl/bdf_front.sv
rtl/bdf_back.sv
rtl/broadcast_duplicate_filter.sv
dv/tb_top.sv
